@@ hw/rtl/pagbp_pkg.sv @@
// Shared constants, types and helper functions of the PAg branch predictor.
`default_nettype none

package pagbp_pkg;

  localparam int HIST_BITS   = 10;
  localparam int SELECT_BITS = 10;

  // One initialization pass covers the deeper of the two tables.
  localparam int SWEEP_BITS = (SELECT_BITS > HIST_BITS) ? SELECT_BITS : HIST_BITS;

  localparam int ADDR_W    = 32;
  localparam int CTR_W     = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int CFG_IDX_W = PADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_INIT_CTR = CFG_IDX_W'(0);

  localparam logic [CTR_W-1:0] CTR_MIN        = CTR_W'(0);
  localparam logic [CTR_W-1:0] CTR_MAX        = CTR_W'(3);
  localparam logic [CTR_W-1:0] CTR_TAKEN_THR  = CTR_W'(2);
  localparam logic [CTR_W-1:0] CTR_RESET_INIT = CTR_W'(1);

  typedef logic [HIST_BITS-1:0]   hist_t;
  typedef logic [SELECT_BITS-1:0] sel_t;
  typedef logic [CTR_W-1:0]       ctr_t;

  // Saturating step toward the resolved outcome.
  function automatic ctr_t ctr_update(input ctr_t ctr, input logic taken);
    ctr_t res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + CTR_W'(1);
    end else begin
      if (ctr != CTR_MIN) res = ctr - CTR_W'(1);
    end
    return res;
  endfunction

  // Outcome enters as the new LSB; the oldest bit falls off the top.
  function automatic hist_t hist_shift(input hist_t hist, input logic taken);
    logic [HIST_BITS:0] wide;
    wide = {hist, taken};
    return wide[HIST_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pagbp_chan_if.sv @@
// Request and response channel interfaces of the PAg branch predictor.
`default_nettype none

interface pagbp_req_if;
  logic                       valid;
  logic                       ready;
  logic [pagbp_pkg::ADDR_W-1:0] branch_address;
  logic                       actual_taken;

  modport source (output valid, output branch_address, output actual_taken, input ready);
  modport sink   (input valid, input branch_address, input actual_taken, output ready);
endinterface

interface pagbp_rsp_if;
  logic valid;
  logic ready;
  logic predicted_taken;
  logic mispredicted;

  modport source (output valid, output predicted_taken, output mispredicted, input ready);
  modport sink   (input valid, input predicted_taken, input mispredicted, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pagbp_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module pagbp_ram #(
  parameter int WIDTH     = 2,
  parameter int ADDR_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output      logic [WIDTH-1:0]     rd_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/pag_branch_predictor_unit.sv @@
// Top level of the PAg two-level branch predictor.
// Each request carries a branch address and its resolved outcome and yields one
// response with the prediction made before the update and a miss flag. A
// request first reads the per-address history memory in its accept cycle,
// then reads the shared pattern-counter memory at that history, and then,
// once the response register is free or being taken, writes the stepped
// counter and the shifted history back and loads the response register. The
// two reads depend on each other and only one request is in flight at a time,
// so each request's writes land before the next one's reads; no forwarding is
// needed. A new request is accepted while an earlier response still waits.
// After reset and after every write of initial_counter (register 0, byte
// address 0) the block runs an initialization pass over 2**max(SELECT_BITS,
// HIST_BITS) entries (1024 as built) that loads the counters and, after reset,
// clears the histories; no request is accepted during that pass.
`default_nettype none

module pag_branch_predictor_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pagbp_req_if.sink                          req,
  pagbp_rsp_if.source                        rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pagbp_pkg::PADDR_W-1:0] paddr,
  input  wire logic [pagbp_pkg::PDATA_W-1:0] pwdata,
  output      logic [pagbp_pkg::PDATA_W-1:0] prdata,
  output      logic                          pready
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HIST  = 4'b0100,
    ST_CTR   = 4'b1000
  } state_t;

  state_t                            state, state_next;
  logic [pagbp_pkg::SWEEP_BITS-1:0]  sweep_idx;
  logic                              clear_hist;
  pagbp_pkg::ctr_t                   init_ctr;
  pagbp_pkg::sel_t                   sel;
  logic                              taken;
  pagbp_pkg::hist_t                  hidx;
  logic                              out_valid;
  logic                              out_pred;
  logic                              out_miss;

  logic              req_fire;
  logic              commit;
  logic              sweeping;
  logic              sweep_last;
  logic              cfg_wr;
  logic              cfg_hit;
  logic              pred;
  pagbp_pkg::hist_t  hist_rd_data;
  pagbp_pkg::ctr_t   ctr_rd_data;
  logic              hist_wr_en;
  pagbp_pkg::sel_t   hist_wr_addr;
  pagbp_pkg::hist_t  hist_wr_data;
  logic              ctr_wr_en;
  pagbp_pkg::hist_t  ctr_wr_addr;
  pagbp_pkg::ctr_t   ctr_wr_data;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_hit = cfg_wr && (paddr[pagbp_pkg::PADDR_W-1:2] == pagbp_pkg::CFG_IDX_INIT_CTR);
  assign prdata  = (paddr[pagbp_pkg::PADDR_W-1:2] == pagbp_pkg::CFG_IDX_INIT_CTR)
                   ? pagbp_pkg::PDATA_W'(init_ctr) : '0;

  // Handshakes
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign commit    = (state == ST_CTR) && (!out_valid || rsp.ready);
  assign sweeping  = (state == ST_CLEAR);
  assign sweep_last = &sweep_idx;

  assign rsp.valid           = out_valid;
  assign rsp.predicted_taken = out_pred;
  assign rsp.mispredicted    = out_miss;

  assign pred = (ctr_rd_data >= pagbp_pkg::CTR_TAKEN_THR);

  // Memory ports: the init pass owns the write ports, otherwise the commit does.
  assign hist_wr_en   = (sweeping && clear_hist) || commit;
  assign hist_wr_addr = sweeping ? sweep_idx[pagbp_pkg::SELECT_BITS-1:0] : sel;
  assign hist_wr_data = sweeping ? '0 : pagbp_pkg::hist_shift(hidx, taken);

  assign ctr_wr_en   = sweeping || commit;
  assign ctr_wr_addr = sweeping ? sweep_idx[pagbp_pkg::HIST_BITS-1:0] : hidx;
  assign ctr_wr_data = sweeping ? init_ctr : pagbp_pkg::ctr_update(ctr_rd_data, taken);

  pagbp_ram #(
    .WIDTH     (pagbp_pkg::HIST_BITS),
    .ADDR_BITS (pagbp_pkg::SELECT_BITS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_wr_en),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_en   (req_fire),
    .rd_addr (req.branch_address[pagbp_pkg::SELECT_BITS-1:0]),
    .rd_data (hist_rd_data)
  );

  pagbp_ram #(
    .WIDTH     (pagbp_pkg::CTR_W),
    .ADDR_BITS (pagbp_pkg::HIST_BITS)
  ) u_ctr_ram (
    .clk     (clk),
    .wr_en   (ctr_wr_en),
    .wr_addr (ctr_wr_addr),
    .wr_data (ctr_wr_data),
    .rd_en   (state == ST_HIST),
    .rd_addr (hist_rd_data),
    .rd_data (ctr_rd_data)
  );

  // Sequencer. Writes land before the next request's reads, so no forwarding.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sweep_last) state_next = ST_IDLE;
      ST_IDLE:  if (req_fire) state_next = ST_HIST;
      ST_HIST:  state_next = ST_CTR;
      ST_CTR:   if (commit) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
    if (cfg_hit) state_next = ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep_idx  <= '0;
      clear_hist <= 1'b1;
      init_ctr   <= pagbp_pkg::CTR_RESET_INIT;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        init_ctr  <= pwdata[pagbp_pkg::CTR_W-1:0];
        sweep_idx <= '0;
      end else if (sweeping) begin
        sweep_idx <= sweep_idx + pagbp_pkg::SWEEP_BITS'(1);
        if (sweep_last) clear_hist <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      sel   <= req.branch_address[pagbp_pkg::SELECT_BITS-1:0];
      taken <= req.actual_taken;
    end
    if (state == ST_HIST) hidx <= hist_rd_data;
    if (commit) begin
      out_pred <= pred;
      out_miss <= pred ^ taken;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pagbp_checker.sv @@
// Port-level assertions for the PAg branch predictor, bound to the top level.
`default_nettype none

module pagbp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic                          rsp_pred,
  input wire logic                          rsp_miss,
  input wire logic                          psel,
  input wire logic                          penable,
  input wire logic                          pwrite,
  input wire logic [pagbp_pkg::PADDR_W-1:0] paddr,
  input wire logic                          pready
);

  // No response is pending right after reset.
  a_no_rsp_after_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pred) && $stable(rsp_miss))
    else $error("stalled response changed");

  // One request at a time: the cycle after an accept takes no request.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while one is in flight");

  // A write of initial_counter starts the counter load; no request until it ends.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready &&
    (paddr[pagbp_pkg::PADDR_W-1:2] == pagbp_pkg::CFG_IDX_INIT_CTR) |=> !req_ready)
    else $error("request taken right after configuration write");

endmodule

bind pag_branch_predictor_unit pagbp_checker u_pagbp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_pred  (rsp.predicted_taken),
  .rsp_miss  (rsp.mispredicted),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pready    (pready)
);

`default_nettype wire

@@ tb/sv/tb_pag_branch_predictor_unit.sv @@
// Testbench of the PAg branch predictor: random branch streams checked against a local model.
module tb_pag_branch_predictor_unit;
  import pagbp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int POOL_SIZE   = 6;
  localparam int POOL_IDX_W  = $clog2(POOL_SIZE);
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 60;

  localparam logic [PADDR_W-1:0] ADDR_INIT_CTR = {CFG_IDX_INIT_CTR, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = {CFG_IDX_W'(1), 2'b00};

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              actual_taken;
  } branch_t;

  typedef struct packed {
    logic predicted_taken;
    logic mispredicted;
  } outcome_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  pagbp_req_if req_ch ();
  pagbp_rsp_if rsp_ch ();

  pag_branch_predictor_unit uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local copy of the predictor state
  hist_t history_mem [2**SELECT_BITS];
  ctr_t  counter_mem [2**HIST_BITS];
  ctr_t  init_counter;

  branch_t  pending_branches [$];
  outcome_t expected_outcomes [$];

  branch_t  next_branch;
  outcome_t got_outcome;
  outcome_t want_outcome;
  logic     req_accepted;
  logic     no_idle;
  int       fail_cnt;
  int       rsp_count;
  int       cycle_cnt;
  int       hold_left;
  logic     hold_done;

  sel_t pool_sel [POOL_SIZE];
  int   loop_len [POOL_SIZE];
  int   loop_pos [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void fill_counters(input ctr_t value);
    for (int i = 0; i < 2**HIST_BITS; i++) counter_mem[HIST_BITS'(i)] = value;
  endfunction

  function automatic outcome_t resolve_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    outcome_t res;
    sel_t     sel;
    hist_t    idx;
    ctr_t     ctr;
    sel = addr[SELECT_BITS-1:0];
    idx = history_mem[sel];
    ctr = counter_mem[idx];
    res.predicted_taken = (ctr >= CTR_TAKEN_THR);
    res.mispredicted    = res.predicted_taken != taken;
    if (taken) begin
      if (ctr != CTR_MAX) ctr = ctr + CTR_W'(1);
    end else begin
      if (ctr != CTR_MIN) ctr = ctr - CTR_W'(1);
    end
    counter_mem[idx] = ctr;
    history_mem[sel] = {history_mem[sel][HIST_BITS-2:0], taken};
    return res;
  endfunction

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_accepted) begin
      if (pending_branches.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
        next_branch = pending_branches.pop_front();
        req_ch.valid          <= 1'b1;
        req_ch.branch_address <= next_branch.branch_address;
        req_ch.actual_taken   <= next_branch.actual_taken;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response side: random stalls plus one long hold-off to back up the pipeline
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= 10);
    end
  end

  // Predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    req_accepted <= req_ch.valid && req_ch.ready && !rst;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        expected_outcomes.push_back(resolve_branch(req_ch.branch_address, req_ch.actual_taken));
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_count <= rsp_count + 1;
        got_outcome.predicted_taken = rsp_ch.predicted_taken;
        got_outcome.mispredicted    = rsp_ch.mispredicted;
        if (expected_outcomes.size() == 0) begin
          $error("response with no request outstanding: predicted_taken %0d mispredicted %0d",
                 got_outcome.predicted_taken, got_outcome.mispredicted);
          fail_cnt++;
        end else begin
          want_outcome = expected_outcomes.pop_front();
          if (got_outcome.predicted_taken !== want_outcome.predicted_taken) begin
            $error("predicted_taken: expected %0d, got %0d",
                   want_outcome.predicted_taken, got_outcome.predicted_taken);
            fail_cnt++;
          end
          if (got_outcome.mispredicted !== want_outcome.mispredicted) begin
            $error("mispredicted: expected %0d, got %0d",
                   want_outcome.mispredicted, got_outcome.mispredicted);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_pag_branch_predictor_unit failed");
      $finish;
    end
  end

  task automatic push_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    branch_t br;
    br.branch_address = addr;
    br.actual_taken   = taken;
    pending_branches.push_back(br);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    #1;
    while (pending_branches.size() != 0 || req_ch.valid || expected_outcomes.size() != 0) begin
      @(posedge clk);
      #1;
    end
    // let the last update settle before touching the tables
    repeat (8) @(posedge clk);
    #1;
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr[PADDR_W-1:2] == CFG_IDX_INIT_CTR) begin
      init_counter = data[CTR_W-1:0];
      fill_counters(init_counter);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_init_counter();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_INIT_CTR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[CTR_W-1:0] !== init_counter) begin
      $error("initial_counter: expected %0d, got %0d", init_counter, prdata[CTR_W-1:0]);
      fail_cnt++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly loop-like branches on a few hot addresses, some noise and stray addresses
  task automatic gen_branches(input int count);
    logic [ADDR_W-1:0]     rnd;
    logic                  taken;
    logic [POOL_IDX_W-1:0] k;
    int                    pick;
    for (int i = 0; i < POOL_SIZE; i++) begin
      rnd                        = $urandom();
      pool_sel[POOL_IDX_W'(i)]   = rnd[SELECT_BITS-1:0];
      loop_len[POOL_IDX_W'(i)]   = $urandom_range(12, 2);
      loop_pos[POOL_IDX_W'(i)]   = 0;
    end
    for (int n = 0; n < count; n++) begin
      rnd  = $urandom();
      pick = $urandom_range(99);
      k    = POOL_IDX_W'($urandom_range(POOL_SIZE - 1));
      if (pick < 70) begin
        taken = (loop_pos[k] != loop_len[k] - 1);
        loop_pos[k] = (loop_pos[k] + 1) % loop_len[k];
        if ($urandom_range(19) == 0) taken = ~taken;
        push_branch({rnd[ADDR_W-1:SELECT_BITS], pool_sel[k]}, taken);
      end else if (pick < 85) begin
        push_branch({rnd[ADDR_W-1:SELECT_BITS], pool_sel[k]}, 1'($urandom_range(1)));
      end else begin
        push_branch(rnd, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic configure(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    wait_idle();
    apb_write(addr, data);
    check_init_counter();
  endtask

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    req_ch.valid          = 1'b0;
    req_ch.branch_address = '0;
    req_ch.actual_taken   = 1'b0;
    rsp_ch.ready          = 1'b0;
    req_accepted          = 1'b0;
    no_idle               = 1'b0;
    fail_cnt              = 0;
    rsp_count             = 0;
    cycle_cnt             = 0;
    hold_left             = 0;
    hold_done             = 1'b0;
    init_counter          = CTR_RESET_INIT;
    for (int i = 0; i < 2**SELECT_BITS; i++) history_mem[SELECT_BITS'(i)] = '0;
    fill_counters(init_counter);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: address extremes, aliasing on the select bits
    push_branch(32'h0000_0000, 1'b1);
    push_branch(32'hFFFF_FFFF, 1'b0);
    push_branch(32'h0000_0400, 1'b1);
    push_branch(32'hFFFF_FC00, 1'b0);
    // long taken run: history wraps, counter saturates at the top
    for (int i = 0; i < 14; i++) push_branch(32'h0000_0155, 1'b1);
    // not-taken run on a clean history: counter saturates at the bottom
    for (int i = 0; i < 5; i++) push_branch(32'hA5A5_A2AA, 1'b0);
    push_branch(32'h0000_0155, 1'b0);
    check_init_counter();

    configure(ADDR_INIT_CTR, 32'hFFFF_FFFF);
    gen_branches(150);

    configure(ADDR_INIT_CTR, 32'hFFFF_FFFC);
    wait_idle();
    no_idle = 1'b1;
    gen_branches(150);
    wait_idle();
    no_idle = 1'b0;

    // unmapped register: no effect on the counters
    configure(ADDR_UNMAPPED, 32'h0000_0002);
    gen_branches(150);

    configure(ADDR_INIT_CTR, 32'h0000_0002);
    gen_branches(150);

    configure(ADDR_INIT_CTR, 32'h5555_5555);
    gen_branches(150);

    configure(ADDR_INIT_CTR, 32'h0000_0003);
    gen_branches(180);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_pag_branch_predictor_unit passed");
    end else begin
      $display("tb_pag_branch_predictor_unit failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/pagbp_pkg.sv
hw/rtl/pagbp_chan_if.sv
hw/rtl/pagbp_ram.sv
hw/rtl/pag_branch_predictor_unit.sv
hw/rtl/pagbp_checker.sv
tb/sv/tb_pag_branch_predictor_unit.sv
